@@ src/qste_pkg.sv @@
// Shared types and constants for the queue and stack transfer engine.
// No dependencies.
package qste_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int LEVEL_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 3'd0,
        OP_DEQ  = 3'd1,
        OP_PUSH = 3'd2,
        OP_POP  = 3'd3,
        OP_Q2S  = 3'd4,
        OP_S2Q  = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_XFER,
        S_RESP
    } state_t;

endpackage

@@ src/qste_if.sv @@
// Valid/ready channel interfaces for op beats and result beats.
// Payload widths follow the op and result field definitions.
interface qste_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface qste_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               removed_valid;
    logic signed [31:0] removed_value;
    logic [4:0]         queue_level;
    logic [4:0]         stack_level;

    modport source (output valid, output status, output removed_valid,
                    output removed_value, output queue_level, output stack_level,
                    input ready);
    modport sink   (input valid, input status, input removed_valid,
                    input removed_value, input queue_level, input stack_level,
                    output ready);
endinterface

@@ src/queue_and_stack_transfer_engine.sv @@
// Queue and stack transfer engine: sequencer plus one store each for queue and stack.
// Each op runs S_EXEC, then S_READ for a dequeue or pop that finds an entry, or S_XFER for
// a transfer from a non-empty source (one entry per cycle until the source is empty or
// the target full, then the last entry read is written back), then S_RESP. Ops run one
// at a time; the next op beat is taken once the result sits in the output register.
// Reset clears state, queue head, both counts, the pending flag and output valid only.
module queue_and_stack_transfer_engine
    import qste_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    qste_in_if.sink    req,
    qste_out_if.source rsp
);

    localparam int AW = $clog2(DEPTH);

    logic              q_we, q_re, s_we, s_re;
    logic [AW-1:0]     q_waddr, q_raddr, s_waddr, s_raddr;
    logic [DATA_W-1:0] q_wdata, q_rdata, s_wdata, s_rdata;

    qste_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .q_we    (q_we),
        .q_waddr (q_waddr),
        .q_wdata (q_wdata),
        .q_re    (q_re),
        .q_raddr (q_raddr),
        .q_rdata (q_rdata),
        .s_we    (s_we),
        .s_waddr (s_waddr),
        .s_wdata (s_wdata),
        .s_re    (s_re),
        .s_raddr (s_raddr),
        .s_rdata (s_rdata)
    );

    qste_ram #(.DEPTH(DEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    qste_ram #(.DEPTH(DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

endmodule

@@ src/qste_ram.sv @@
// Single-port-write, single-port-read synchronous store with registered read data.
// Depends on qste_pkg for the data width.
module qste_ram
    import qste_pkg::*;
#(
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/qste_ctrl.sv @@
// Sequencer for the queue and stack: pointers, counts, store accesses, result register.
// Depends on qste_pkg and the channel interfaces in qste_if.
module qste_ctrl
    import qste_pkg::*;
#(
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    qste_in_if.sink           req,
    qste_out_if.source        rsp,
    output logic              q_we,
    output logic [AW-1:0]     q_waddr,
    output logic [DATA_W-1:0] q_wdata,
    output logic              q_re,
    output logic [AW-1:0]     q_raddr,
    input  logic [DATA_W-1:0] q_rdata,
    output logic              s_we,
    output logic [AW-1:0]     s_waddr,
    output logic [DATA_W-1:0] s_wdata,
    output logic              s_re,
    output logic [AW-1:0]     s_raddr,
    input  logic [DATA_W-1:0] s_rdata
);

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [AW-1:0]       qhead_reg, qhead_next;
    logic [CW-1:0]       qcount_reg, qcount_next;
    logic [CW-1:0]       scount_reg, scount_next;
    status_t             status_reg, status_next;
    logic                rvalid_reg, rvalid_next;
    logic [DATA_W-1:0]   rvalue_reg, rvalue_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;

    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic                out_rvalid_reg, out_rvalid_next;
    logic [DATA_W-1:0]   out_rvalue_reg, out_rvalue_next;
    logic [LEVEL_W-1:0]  out_qlevel_reg, out_qlevel_next;
    logic [LEVEL_W-1:0]  out_slevel_reg, out_slevel_next;

    logic                q_full, q_empty, s_full, s_empty;
    logic [CW:0]         qsum, qtail_full;
    logic [AW-1:0]       qtail, qhead_inc, s_top, s_wr;
    logic [CW-1:0]       s_top_full;
    logic                issue;
    logic [CW+LEVEL_W-1:0] qlevel_ext, slevel_ext;

    assign q_full     = (qcount_reg == CW'(DEPTH));
    assign q_empty    = (qcount_reg == '0);
    assign s_full     = (scount_reg == CW'(DEPTH));
    assign s_empty    = (scount_reg == '0);
    assign qsum       = {1'b0, qcount_reg} + (CW+1)'(qhead_reg);
    assign qtail_full = (qsum >= (CW+1)'(DEPTH)) ? qsum - (CW+1)'(DEPTH) : qsum;
    assign qtail      = qtail_full[AW-1:0];
    assign qhead_inc  = (qhead_reg == AW'(DEPTH - 1)) ? '0 : qhead_reg + 1'b1;
    assign s_top_full = scount_reg - 1'b1;
    assign s_top      = s_top_full[AW-1:0];
    assign s_wr       = scount_reg[AW-1:0];
    assign issue      = (op_reg == OP_Q2S) ? (!q_empty && !s_full) : (!s_empty && !q_full);
    assign qlevel_ext = {{LEVEL_W{1'b0}}, qcount_reg};
    assign slevel_ext = {{LEVEL_W{1'b0}}, scount_reg};

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_valid = out_rvalid_reg;
    assign rsp.removed_value = out_rvalue_reg;
    assign rsp.queue_level   = out_qlevel_reg;
    assign rsp.stack_level   = out_slevel_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_DEQ:  state_next = q_empty ? S_RESP : S_READ;
                    OP_POP:  state_next = s_empty ? S_RESP : S_READ;
                    OP_Q2S:  state_next = q_empty ? S_RESP : S_XFER;
                    OP_S2Q:  state_next = s_empty ? S_RESP : S_XFER;
                    default: state_next = S_RESP;
                endcase
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_XFER:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        value_next      = value_reg;
        qhead_next      = qhead_reg;
        qcount_next     = qcount_reg;
        scount_next     = scount_reg;
        status_next     = status_reg;
        rvalid_next     = rvalid_reg;
        rvalue_next     = rvalue_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rvalid_next = out_rvalid_reg;
        out_rvalue_next = out_rvalue_reg;
        out_qlevel_next = out_qlevel_reg;
        out_slevel_next = out_slevel_reg;
        q_we    = 1'b0;
        q_waddr = qtail;
        q_wdata = value_reg;
        q_re    = 1'b0;
        q_raddr = qhead_reg;
        s_we    = 1'b0;
        s_waddr = s_wr;
        s_wdata = value_reg;
        s_re    = 1'b0;
        s_raddr = s_top;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    value_next  = req.value;
                    status_next = STAT_OK;
                    rvalid_next = 1'b0;
                    rvalue_next = '0;
                    pend_next   = 1'b0;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ENQ:
                    begin
                        if (q_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            q_we        = 1'b1;
                            qcount_next = qcount_reg + 1'b1;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (q_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            q_re        = 1'b1;
                            qhead_next  = qhead_inc;
                            qcount_next = qcount_reg - 1'b1;
                            rvalid_next = 1'b1;
                        end
                    end
                    OP_PUSH:
                    begin
                        if (s_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            s_we        = 1'b1;
                            scount_next = scount_reg + 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (s_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            s_re        = 1'b1;
                            scount_next = scount_reg - 1'b1;
                            rvalid_next = 1'b1;
                        end
                    end
                    OP_Q2S:
                    begin
                        if (q_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    OP_S2Q:
                    begin
                        if (s_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            S_READ:
            begin
                rvalue_next = (op_reg == OP_DEQ) ? q_rdata : s_rdata;
            end
            S_XFER:
            begin
                pend_next = issue;
                if (op_reg == OP_Q2S)
                begin
                    // write back the element read last cycle
                    s_we    = pend_reg;
                    s_waddr = pend_addr_reg;
                    s_wdata = q_rdata;
                    if (issue)
                    begin
                        q_re           = 1'b1;
                        qhead_next     = qhead_inc;
                        qcount_next    = qcount_reg - 1'b1;
                        scount_next    = scount_reg + 1'b1;
                        pend_addr_next = s_wr;
                    end
                    status_next = q_empty ? STAT_OK : STAT_FULL;
                end
                else
                begin
                    q_we    = pend_reg;
                    q_waddr = pend_addr_reg;
                    q_wdata = s_rdata;
                    if (issue)
                    begin
                        s_re           = 1'b1;
                        scount_next    = scount_reg - 1'b1;
                        qcount_next    = qcount_reg + 1'b1;
                        pend_addr_next = qtail;
                    end
                    status_next = s_empty ? STAT_OK : STAT_FULL;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rvalid_next = rvalid_reg;
                    out_rvalue_next = rvalue_reg;
                    out_qlevel_next = qlevel_ext[LEVEL_W-1:0];
                    out_slevel_next = slevel_ext[LEVEL_W-1:0];
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qhead_reg     <= '0;
            qcount_reg    <= '0;
            scount_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            qhead_reg     <= qhead_next;
            qcount_reg    <= qcount_next;
            scount_reg    <= scount_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        rvalid_reg     <= rvalid_next;
        rvalue_reg     <= rvalue_next;
        pend_addr_reg  <= pend_addr_next;
        out_status_reg <= out_status_next;
        out_rvalid_reg <= out_rvalid_next;
        out_rvalue_reg <= out_rvalue_next;
        out_qlevel_reg <= out_qlevel_next;
        out_slevel_reg <= out_slevel_next;
    end

endmodule
